@@ hdl/pfsp_pkg.sv @@
`default_nettype none

package pfsp_pkg;

    localparam int unsigned VAL_W = 31;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    // result kinds
    localparam logic [1:0] KIND_LIT  = 2'd0;
    localparam logic [1:0] KIND_SPEC = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // conversion codes
    localparam logic [3:0] CONV_NONE = 4'd0;
    localparam logic [3:0] CONV_C    = 4'd1;
    localparam logic [3:0] CONV_S    = 4'd2;
    localparam logic [3:0] CONV_P    = 4'd3;
    localparam logic [3:0] CONV_D    = 4'd4;
    localparam logic [3:0] CONV_I    = 4'd5;
    localparam logic [3:0] CONV_U    = 4'd6;
    localparam logic [3:0] CONV_LX   = 4'd7;
    localparam logic [3:0] CONV_UX   = 4'd8;
    localparam logic [3:0] CONV_PCT  = 4'd9;

    // format characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_LS    = 8'h73;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LI    = 8'h69;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       char_out;
        logic             left_align;
        logic             zero_pad;
        logic [VAL_W-1:0] field_width;
        logic             has_precision;
        logic [VAL_W-1:0] precision;
        logic [3:0]       conversion;
        logic             last;
    } t_result;

    function automatic logic [3:0] conv_code(input logic [7:0] c);
        logic [3:0] code;
        case (c)
            CH_LC:   code = CONV_C;
            CH_LS:   code = CONV_S;
            CH_LP:   code = CONV_P;
            CH_LD:   code = CONV_D;
            CH_LI:   code = CONV_I;
            CH_LU:   code = CONV_U;
            CH_LX:   code = CONV_LX;
            CH_UX:   code = CONV_UX;
            CH_PCT:  code = CONV_PCT;
            default: code = CONV_NONE;
        endcase
        return code;
    endfunction

    // acc * 10 + digit, saturating
    function automatic logic [VAL_W-1:0] times_ten_plus(input logic [VAL_W-1:0] acc,
                                                        input logic [7:0] c);
        logic [7:0]       d;
        logic [VAL_W+3:0] v;
        d = c - CH_0;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{(VAL_W){1'b0}}, d[3:0]};
        return (v[VAL_W+3:VAL_W] != 4'b0) ? VAL_MAX : v[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/printf_format_spec_parser_unit.sv @@
// printf format specifier parser
// input stream: one format string byte per transfer, with the star argument
// alongside; output stream: literal bytes, completed specifiers and end of
// string markers, kind on tuser, tlast on the final result of each input byte.
// one byte is taken per cycle while o_s_tready is high; its results are formed
// in the accepting cycle and registered into the result queue.
// a byte gives zero, one or two results; they go into a three-entry result
// queue that also acts as skid buffer, and o_s_tready is high while at most
// one entry is occupied. with one result per byte and no stall the block runs
// at one byte per cycle; a byte giving two results leaves two entries to drain,
// so o_s_tready may drop after it while the queue drains.
// when the receiver stalls the queue fills and o_s_tready drops; nothing is
// lost. reset (synchronous, active low) empties the queue and returns the
// parser to text phase with all specifier fields cleared.
`default_nettype none

module printf_format_spec_parser_unit
    import pfsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // char_in[7:0], star_value[39:8]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [79:0]      o_m_tdata,   // char_out[7:0], left_align[8], zero_pad[9],
                                          // field_width[40:10], has_precision[41],
                                          // precision[72:42], conversion[76:73], zeros
    output logic [1:0]       o_m_tuser,   // kind[1:0]
    output logic             o_m_tlast    // last
);

    localparam int unsigned DEPTH = 3;

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_FLAGS,
        PH_WDIG,
        PH_AFTERDOT,
        PH_PDIG
    } t_phase;

    t_phase           r_phase, n_phase;
    logic             r_align, n_align;
    logic             r_zero, n_zero;
    logic [VAL_W-1:0] r_width, n_width;
    logic             r_dot, n_dot;
    logic [VAL_W-1:0] r_prec, n_prec;

    t_result          r_q [DEPTH];
    t_result          n_q [DEPTH];
    logic [1:0]       r_cnt, n_cnt;

    logic [7:0]       c;
    logic [31:0]      v;
    logic             accept, pop, is_digit;
    logic [VAL_W-1:0] width_dig, prec_dig;
    logic [31:0]      mag;
    logic [3:0]       conv;
    t_result          res0, res1, spec_res;
    logic             push0, push1;
    logic             do_finish, do_prec_entry, do_prec_star;
    logic [1:0]       base;

    assign c = i_s_tdata[7:0];
    assign v = i_s_tdata[39:8];

    assign o_s_tready = (r_cnt <= 2'd1);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign pop        = o_m_tvalid && i_m_tready;

    assign is_digit  = (c inside {[CH_0:CH_9]});
    assign width_dig = times_ten_plus(r_width, c);
    assign prec_dig  = times_ten_plus(r_prec, c);
    assign mag       = 32'd0 - v;
    assign conv      = conv_code(c);

    always_comb begin
        spec_res               = '0;
        spec_res.kind          = KIND_SPEC;
        spec_res.left_align    = r_align;
        spec_res.zero_pad      = r_zero & ~r_align;
        spec_res.field_width   = r_width;
        spec_res.has_precision = r_dot;
        spec_res.precision     = r_prec;
        spec_res.conversion    = conv;
    end

    // phase decode
    always_comb begin
        n_phase       = r_phase;
        n_align       = r_align;
        n_zero        = r_zero;
        n_width       = r_width;
        n_dot         = r_dot;
        n_prec        = r_prec;
        res0          = '0;
        res1          = '0;
        push0         = 1'b0;
        push1         = 1'b0;
        do_finish     = 1'b0;
        do_prec_entry = 1'b0;
        do_prec_star  = 1'b0;

        case (r_phase)
            PH_FLAGS: begin
                if (c == CH_MINUS) begin
                    n_align = 1'b1;
                end else if (c == CH_0) begin
                    n_zero = 1'b1;
                end else if (c == CH_STAR) begin
                    if (v[31]) begin
                        n_width = mag[31] ? VAL_MAX : mag[VAL_W-1:0];
                        n_align = 1'b1;
                        n_zero  = 1'b0;
                    end else begin
                        n_width = v[VAL_W-1:0];
                    end
                    n_phase = PH_WDIG;
                end else if (is_digit) begin
                    n_width = width_dig;
                    n_phase = PH_WDIG;
                end else begin
                    do_prec_entry = 1'b1;
                end
            end
            PH_WDIG: begin
                if (is_digit) begin
                    n_width = width_dig;
                end else begin
                    do_prec_entry = 1'b1;
                end
            end
            PH_AFTERDOT: begin
                if (c == CH_STAR) begin
                    do_prec_star = 1'b1;
                end else if (is_digit) begin
                    n_prec  = prec_dig;
                    n_phase = PH_PDIG;
                end else begin
                    do_finish = 1'b1;
                end
            end
            PH_PDIG: begin
                if (is_digit) begin
                    n_prec = prec_dig;
                end else begin
                    do_finish = 1'b1;
                end
            end
            default: begin
                n_phase = PH_TEXT;
                if (c == CH_NUL) begin
                    res0.kind = KIND_END;
                    res0.last = 1'b1;
                    push0     = 1'b1;
                end else if (c == CH_PCT) begin
                    n_phase = PH_FLAGS;
                    n_align = 1'b0;
                    n_zero  = 1'b0;
                    n_width = '0;
                    n_dot   = 1'b0;
                    n_prec  = '0;
                end else begin
                    res0.kind     = KIND_LIT;
                    res0.char_out = c;
                    res0.last     = 1'b1;
                    push0         = 1'b1;
                end
            end
        endcase

        if (do_prec_entry) begin
            if (c == CH_DOT) begin
                n_dot   = 1'b1;
                n_phase = PH_AFTERDOT;
            end else if (c == CH_STAR) begin
                do_prec_star = 1'b1;
            end else begin
                do_finish = 1'b1;
            end
        end

        if (do_prec_star) begin
            if (v[31]) begin
                n_prec = '0;
                n_dot  = 1'b0;
            end else begin
                n_prec = v[VAL_W-1:0];
            end
            n_phase = PH_PDIG;
        end

        if (do_finish) begin
            res0    = spec_res;
            push0   = 1'b1;
            n_align = 1'b0;
            n_zero  = 1'b0;
            n_width = '0;
            n_dot   = 1'b0;
            n_prec  = '0;
            n_phase = PH_TEXT;
            if (conv != CONV_NONE) begin
                res0.last = 1'b1;
            end else if (c == CH_PCT) begin
                // an invalid letter that is itself a percent cannot occur here
                res0.last = 1'b1;
                n_phase   = PH_FLAGS;
            end else if (c == CH_NUL) begin
                res1.kind = KIND_END;
                res1.last = 1'b1;
                push1     = 1'b1;
            end else begin
                res1.kind     = KIND_LIT;
                res1.char_out = c;
                res1.last     = 1'b1;
                push1         = 1'b1;
            end
        end
    end

    // result queue: entry 0 is the output register
    always_comb begin
        base  = r_cnt - {1'b0, pop};
        n_cnt = base;
        for (int i = 0; i < DEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
        if (accept && push0) begin
            n_q[base] = res0;
            n_cnt     = base + 2'd1;
            if (push1) begin
                n_q[base + 2'd1] = res1;
                n_cnt            = base + 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_align <= 1'b0;
            r_zero  <= 1'b0;
            r_width <= '0;
            r_dot   <= 1'b0;
            r_prec  <= '0;
            r_cnt   <= 2'd0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_align <= n_align;
                r_zero  <= n_zero;
                r_width <= n_width;
                r_dot   <= n_dot;
                r_prec  <= n_prec;
            end
            r_cnt <= n_cnt;
        end
        for (int i = 0; i < DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_m_tdata = {3'b000, r_q[0].conversion, r_q[0].precision, r_q[0].has_precision,
                        r_q[0].field_width, r_q[0].zero_pad, r_q[0].left_align,
                        r_q[0].char_out};
    assign o_m_tuser = r_q[0].kind;
    assign o_m_tlast = r_q[0].last;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pfsp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1350;

    typedef enum logic [2:0] {PH_TEXT, PH_FLAGS, PH_WDIG, PH_DOT, PH_PDIG} t_spec_phase;

    typedef struct {
        logic [7:0]  ch;
        logic [31:0] star;
        bit          drain;
    } t_fmt_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [39:0] s_data = '0;
    logic        m_ready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [79:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    printf_format_spec_parser_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    t_fmt_byte fmt_q[$];
    t_result   spec_q[$];
    int        err_cnt = 0;
    int        cycle_cnt = 0;
    bit        s_fire = 1'b0;
    bit        m_fire = 1'b0;
    bit        mark_drain = 1'b0;

    // parser state mirror
    t_spec_phase       spec_phase = PH_TEXT;
    logic              st_align = 1'b0;
    logic              st_zero = 1'b0;
    logic [VAL_W-1:0]  st_width = '0;
    logic              st_dot = 1'b0;
    logic [VAL_W-1:0]  st_prec = '0;
    t_result           step_out[2];
    int                step_n;

    logic [7:0] conv_chars[9] = '{CH_LC, CH_LS, CH_LP, CH_LD, CH_LI, CH_LU, CH_LX, CH_UX,
                                  CH_PCT};

    function automatic bit is_dec(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic [VAL_W-1:0] dec_push(input logic [VAL_W-1:0] acc,
                                                  input logic [7:0] c);
        logic [35:0] sum;
        logic [7:0]  d;
        d = c - CH_0;
        sum = {5'b0, acc} * 36'd10 + {28'b0, d};
        return (sum > {5'b0, VAL_MAX}) ? VAL_MAX : sum[VAL_W-1:0];
    endfunction

    function automatic logic [3:0] letter_conv(input logic [7:0] c);
        case (c)
            CH_LC:   return CONV_C;
            CH_LS:   return CONV_S;
            CH_LP:   return CONV_P;
            CH_LD:   return CONV_D;
            CH_LI:   return CONV_I;
            CH_LU:   return CONV_U;
            CH_LX:   return CONV_LX;
            CH_UX:   return CONV_UX;
            CH_PCT:  return CONV_PCT;
            default: return CONV_NONE;
        endcase
    endfunction

    task automatic emit_simple(input logic [1:0] k, input logic [7:0] ch);
        t_result r;
        r = '0;
        r.kind = k;
        r.char_out = ch;
        step_out[step_n] = r;
        step_n++;
    endtask

    task automatic emit_spec(input logic [3:0] conv);
        t_result r;
        r = '0;
        r.kind = KIND_SPEC;
        r.left_align = st_align;
        r.zero_pad = st_zero & ~st_align;
        r.field_width = st_width;
        r.has_precision = st_dot;
        r.precision = st_prec;
        r.conversion = conv;
        step_out[step_n] = r;
        step_n++;
    endtask

    task automatic clear_fields();
        st_align = 1'b0;
        st_zero = 1'b0;
        st_width = '0;
        st_dot = 1'b0;
        st_prec = '0;
    endtask

    task automatic text_byte(input logic [7:0] c);
        if (c == CH_NUL) begin
            emit_simple(KIND_END, CH_NUL);
        end else if (c == CH_PCT) begin
            clear_fields();
            spec_phase = PH_FLAGS;
        end else begin
            emit_simple(KIND_LIT, c);
        end
    endtask

    task automatic close_spec(input logic [7:0] c);
        logic [3:0] conv;
        conv = letter_conv(c);
        emit_spec(conv);
        clear_fields();
        spec_phase = PH_TEXT;
        // an unknown letter is then taken as ordinary text
        if (conv == CONV_NONE) text_byte(c);
    endtask

    task automatic star_prec(input logic [31:0] v);
        if (v[31]) begin
            st_prec = '0;
            st_dot = 1'b0;
        end else begin
            st_prec = v[VAL_W-1:0];
        end
        spec_phase = PH_PDIG;
    endtask

    task automatic enter_prec(input logic [7:0] c, input logic [31:0] v);
        if (c == CH_DOT) begin
            st_dot = 1'b1;
            spec_phase = PH_DOT;
        end else if (c == CH_STAR) begin
            star_prec(v);
        end else begin
            close_spec(c);
        end
    endtask

    task automatic parse_byte(input logic [7:0] c, input logic [31:0] v);
        logic [31:0] mag;
        step_n = 0;
        case (spec_phase)
            PH_FLAGS: begin
                if (c == CH_MINUS) begin
                    st_align = 1'b1;
                end else if (c == CH_0) begin
                    st_zero = 1'b1;
                end else if (c == CH_STAR) begin
                    if (v[31]) begin
                        mag = 32'd0 - v;
                        st_width = (mag > {1'b0, VAL_MAX}) ? VAL_MAX : mag[VAL_W-1:0];
                        st_align = 1'b1;
                        st_zero = 1'b0;
                    end else begin
                        st_width = v[VAL_W-1:0];
                    end
                    spec_phase = PH_WDIG;
                end else if (is_dec(c)) begin
                    st_width = dec_push(st_width, c);
                    spec_phase = PH_WDIG;
                end else begin
                    enter_prec(c, v);
                end
            end
            PH_WDIG: begin
                if (is_dec(c)) st_width = dec_push(st_width, c);
                else enter_prec(c, v);
            end
            PH_DOT: begin
                if (c == CH_STAR) begin
                    star_prec(v);
                end else if (is_dec(c)) begin
                    st_prec = dec_push(st_prec, c);
                    spec_phase = PH_PDIG;
                end else begin
                    close_spec(c);
                end
            end
            PH_PDIG: begin
                if (is_dec(c)) st_prec = dec_push(st_prec, c);
                else close_spec(c);
            end
            default: begin
                spec_phase = PH_TEXT;
                text_byte(c);
            end
        endcase
        if (step_n > 0) step_out[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++) spec_q.push_back(step_out[i]);
    endtask

    task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (spec_q.size() == 0) begin
            flag_error("result with none pending, kind", 32'(got.kind), 32'd0);
        end else begin
            want = spec_q.pop_front();
            if (got.kind != want.kind)
                flag_error("kind", 32'(got.kind), 32'(want.kind));
            if (got.char_out != want.char_out)
                flag_error("char_out", 32'(got.char_out), 32'(want.char_out));
            if (got.left_align != want.left_align)
                flag_error("left_align", 32'(got.left_align), 32'(want.left_align));
            if (got.zero_pad != want.zero_pad)
                flag_error("zero_pad", 32'(got.zero_pad), 32'(want.zero_pad));
            if (got.field_width != want.field_width)
                flag_error("field_width", 32'(got.field_width), 32'(want.field_width));
            if (got.has_precision != want.has_precision)
                flag_error("has_precision", 32'(got.has_precision), 32'(want.has_precision));
            if (got.precision != want.precision)
                flag_error("precision", 32'(got.precision), 32'(want.precision));
            if (got.conversion != want.conversion)
                flag_error("conversion", 32'(got.conversion), 32'(want.conversion));
            if (got.last != want.last)
                flag_error("last", 32'(got.last), 32'(want.last));
        end
    endtask

    // both handshakes are seen here, input side first
    t_result mon_got;
    always @(posedge i_clk) begin
        s_fire = 1'b0;
        m_fire = 1'b0;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end else if (i_rst_n) begin
            if (s_valid && o_s_tready) begin
                s_fire = 1'b1;
                parse_byte(s_data[7:0], s_data[39:8]);
            end
            if (o_m_tvalid && m_ready) begin
                m_fire = 1'b1;
                mon_got.kind = o_m_tuser;
                mon_got.char_out = o_m_tdata[7:0];
                mon_got.left_align = o_m_tdata[8];
                mon_got.zero_pad = o_m_tdata[9];
                mon_got.field_width = o_m_tdata[40:10];
                mon_got.has_precision = o_m_tdata[41];
                mon_got.precision = o_m_tdata[72:42];
                mon_got.conversion = o_m_tdata[76:73];
                mon_got.last = o_m_tlast;
                check_result(mon_got);
            end
        end
    end

    // source side
    int        src_gap = 0;
    bit        src_calm = 1'b0;
    t_fmt_byte drv_item;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (fmt_q.size() != 0 && (!fmt_q[0].drain || spec_q.size() == 0)) begin
                drv_item = fmt_q.pop_front();
                s_data <= {drv_item.star, drv_item.ch};
                s_valid <= 1'b1;
                if ($urandom_range(0, 40) == 0) src_calm = !src_calm;
                src_gap = src_calm ? 0 : $urandom_range(0, 4);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // sink side
    int sink_stall = 0;
    bit sink_calm = 1'b0;
    always @(negedge i_clk) begin
        if (m_fire) begin
            if ($urandom_range(0, 40) == 0) sink_calm = !sink_calm;
            sink_stall = sink_calm ? 0 : $urandom_range(0, 4);
        end
        if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic put(input logic [7:0] ch, input logic [31:0] star);
        t_fmt_byte b;
        b.ch = ch;
        b.star = star;
        b.drain = mark_drain;
        mark_drain = 1'b0;
        fmt_q.push_back(b);
    endtask

    function automatic logic [31:0] pick_star();
        case ($urandom_range(0, 6))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 99);
            3:       return 32'd0 - $urandom_range(1, 99);
            4:       return 32'h8000_0000;
            5:       return 32'h7FFF_FFFF;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic put_digits(input int n);
        for (int i = 0; i < n; i++) put(8'(CH_0 + $urandom_range(0, 9)), $urandom);
    endtask

    // mostly well-formed specifiers with random content
    task automatic gen_spec();
        int nd;
        put(CH_PCT, $urandom);
        repeat ($urandom_range(0, 3)) put($urandom_range(0, 1) ? CH_MINUS : CH_0, $urandom);
        if ($urandom_range(0, 2) == 0) put(CH_STAR, pick_star());
        nd = $urandom_range(0, 9);
        put_digits(nd < 7 ? nd % 3 : (nd < 9 ? 3 : $urandom_range(10, 11)));
        case ($urandom_range(0, 4))
            1: begin
                put(CH_DOT, $urandom);
                put_digits($urandom_range(0, 9) == 0 ? 11 : $urandom_range(0, 3));
            end
            2: begin
                put(CH_DOT, $urandom);
                put(CH_STAR, pick_star());
                put_digits($urandom_range(0, 2));
            end
            3: begin
                put(CH_STAR, pick_star());
                put_digits($urandom_range(0, 2));
            end
            default: ;
        endcase
        case ($urandom_range(0, 11))
            9:       put(8'($urandom_range(0, 255)), $urandom);
            10:      put(CH_NUL, $urandom);
            11:      ;
            default: put(conv_chars[$urandom_range(0, 8)], $urandom);
        endcase
    endtask

    int target;
    initial begin
        // directed: extremes, flags, stars, saturation, unknown letter, nul in spec
        put(8'h41, 32'h0);
        put(8'hFF, 32'hFFFF_FFFF);
        put(CH_NUL, 32'h0);
        put(CH_PCT, 32'h0);
        put(CH_MINUS, 32'h0);
        put(CH_0, 32'h0);
        put(CH_STAR, 32'h8000_0000);
        put(CH_9, 32'h0);
        put(CH_DOT, 32'h0);
        put(CH_STAR, 32'hFFFF_FFFB);
        put(CH_LD, 32'h0);
        put(CH_PCT, 32'h0);
        put(CH_0, 32'h0);
        put(CH_STAR, 32'h7FFF_FFFF);
        put(CH_STAR, 32'd12);
        put(8'h71, 32'h0);
        put(CH_PCT, 32'h0);
        put(CH_DOT, 32'h0);
        put(CH_STAR, 32'h7FFF_FFFF);
        put(CH_0 + 8'd5, 32'h0);
        put(CH_UX, 32'h0);
        put(CH_PCT, 32'h0);
        put(CH_NUL, 32'h0);
        put(CH_PCT, 32'h0);
        put(CH_PCT, 32'h0);
        mark_drain = 1'b1;
        target = fmt_q.size() + RANDOM_ITEMS;
        while (fmt_q.size() < target) begin
            if (fmt_q.size() > target - RANDOM_ITEMS / 2 &&
                fmt_q.size() < target - RANDOM_ITEMS / 2 + 4)
                mark_drain = 1'b1;
            case ($urandom_range(0, 9))
                0, 1:    repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)), $urandom);
                8:       repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)), pick_star());
                9:       put(CH_NUL, $urandom);
                default: gen_spec();
            endcase
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (fmt_q.size() != 0 || s_valid || spec_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        while (spec_q.size() != 0) begin
            flag_error("result never arrived, kind", 32'd0, 32'(spec_q[0].kind));
            void'(spec_q.pop_front());
        end
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/pfsp_pkg.sv
hdl/printf_format_spec_parser_unit.sv
sim/tb.sv
